// File: hw/rtl/ir_pulse_space_capture_filter_top_defines.svh
// assertion macros for the ir pulse/space capture block
`ifndef IR_PULSE_SPACE_CAPTURE_FILTER_TOP_DEFINES_SVH
`define IR_PULSE_SPACE_CAPTURE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IRPSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define IRPSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/irpsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package irpsf_pkg;

    // duration word limits
    localparam logic [23:0] DUR_MAX        = 24'hFFFFFF;
    localparam logic [19:0] MICROS_PER_SEC = 20'd1000000;
    // whole-second gap beyond which the duration always saturates
    localparam logic [31:0] SEC_GAP_SAT    = 32'd17;

    // configuration register indexes
    localparam logic [1:0] CFG_SENSE_INIT  = 2'd0;
    localparam logic [1:0] CFG_GLITCH_LIM  = 2'd1;
    localparam logic [1:0] CFG_LONG_SPACE  = 2'd2;
    localparam logic [1:0] CFG_STALE_SEC   = 2'd3;

    // configuration reset values
    localparam logic        RST_SENSE_INIT = 1'b1;
    localparam logic [23:0] RST_GLITCH_LIM = 24'd250;
    localparam logic [23:0] RST_LONG_SPACE = 24'd20000;
    localparam logic [7:0]  RST_STALE_SEC  = 8'd15;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        line_level;
        logic [31:0] stamp_seconds;
        logic [19:0] stamp_micros;
    } t_in_item;

    typedef struct packed {
        logic [23:0] duration;
        logic        is_pulse;
        logic        last_of_run;
    } t_out_item;

    // saturating add of two duration words
    function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? DUR_MAX : s[23:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ir_pulse_space_capture_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in_data  (irpsf_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out_data (irpsf_pkg::t_out_item)
// cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// an edge is registered, then evaluated combinationally: duration, sense and filter
// update, pushing zero to three words into a four-entry result queue.
// one edge per cycle while the words keep pace with the single-word output port;
// an edge that releases a held space gives two or three words, and the output
// port then sets the pace while the queue drains. an edge passes through the input
// register and then the result queue before its first word is out. synchronous reset
// restores all state but the input data and queue storage. a stalled output holds off
// further input once fewer than three queue entries are free.

`include "ir_pulse_space_capture_filter_top_defines.svh"

module ir_pulse_space_capture_filter_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire irpsf_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output irpsf_pkg::t_out_item      o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [23:0]          i_cfg_data
);

    // configuration
    logic [23:0] r_glitch;
    logic [23:0] r_long;
    logic [7:0]  r_stale;

    // filter and timing state
    logic [31:0] r_prev_sec;
    logic [19:0] r_prev_usec;
    logic        r_pol;
    logic        r_holding;
    logic [23:0] r_hs;
    logic [23:0] r_hp;

    // input register
    logic                r_in_vld;
    irpsf_pkg::t_in_item r_in;

    // result queue
    irpsf_pkg::t_out_item r_queue [irpsf_pkg::QUEUE_DEPTH];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;

    logic        w_pop;
    logic        w_go;
    logic [2:0]  w_cnt_after_pop;

    // duration datapath
    logic        w_sec_lt;
    logic        w_backward;
    logic [31:0] w_sec_diff;
    logic        w_stale;
    logic        w_far;
    logic [24:0] w_mul;
    logic [20:0] w_delta;
    logic [26:0] w_d;
    logic [23:0] w_dur;
    logic        w_pol_eff;
    logic        w_pulse;

    // filter outputs
    logic        n_holding;
    logic [23:0] n_hs;
    logic [23:0] n_hp;
    logic [23:0] w_hp_sum;
    logic [1:0]  w_push_n;
    irpsf_pkg::t_out_item w_word [3];

    // handshake and queue room
    assign w_pop           = (r_cnt != 3'd0) && i_out_ready;
    assign w_cnt_after_pop = r_cnt - {2'b0, w_pop};
    assign w_go            = r_in_vld && (w_cnt_after_pop <= 3'd1);
    assign o_in_ready      = !r_in_vld || w_go;
    assign o_out_valid     = (r_cnt != 3'd0);
    assign o_out_data      = r_queue[r_rp];

    // elapsed time since the previous edge
    assign w_sec_lt   = r_in.stamp_seconds < r_prev_sec;
    assign w_backward = w_sec_lt ||
                        ((r_in.stamp_seconds == r_prev_sec) &&
                         (r_in.stamp_micros < r_prev_usec));
    assign w_sec_diff = r_in.stamp_seconds - r_prev_sec;
    assign w_stale    = w_sec_diff > {24'd0, r_stale};
    assign w_far      = w_sec_diff > irpsf_pkg::SEC_GAP_SAT;
    assign w_mul      = 25'(w_sec_diff[4:0]) * 25'(irpsf_pkg::MICROS_PER_SEC);
    assign w_delta    = {1'b0, r_in.stamp_micros} - {1'b0, r_prev_usec};
    assign w_d        = {2'b0, w_mul} + {{6{w_delta[20]}}, w_delta};

    always_comb begin
        if (w_backward || w_stale || w_far) begin
            w_dur = irpsf_pkg::DUR_MAX;
        end else if (w_d[26]) begin
            w_dur = 24'd0;
        end else if (w_d[25:24] != 2'b00) begin
            w_dur = irpsf_pkg::DUR_MAX;
        end else begin
            w_dur = w_d[23:0];
        end
    end

    // sense flips on a stale pulse so that it is reported as a space
    assign w_pol_eff = (!w_backward && w_stale && (r_in.line_level == r_pol)) ? !r_pol : r_pol;
    assign w_pulse   = (r_in.line_level == w_pol_eff);
    assign w_hp_sum  = irpsf_pkg::sat_add(r_hp, w_dur);

    // noise filter: hold long spaces, fold glitches, release on a real word
    always_comb begin
        n_holding = r_holding;
        n_hs      = r_hs;
        n_hp      = r_hp;
        w_push_n  = 2'd0;
        w_word[0] = '{duration: w_dur, is_pulse: w_pulse, last_of_run: 1'b1};
        w_word[1] = '{duration: w_dur, is_pulse: w_pulse, last_of_run: 1'b1};
        w_word[2] = '{duration: w_dur, is_pulse: w_pulse, last_of_run: 1'b1};
        if (r_holding && w_pulse) begin
            n_hp = w_hp_sum;
            if (w_hp_sum > r_glitch) begin
                w_word[0] = '{duration: r_hs, is_pulse: 1'b0, last_of_run: 1'b0};
                w_word[1] = '{duration: w_hp_sum, is_pulse: 1'b1, last_of_run: 1'b1};
                w_push_n  = 2'd2;
                n_holding = 1'b0;
                n_hp      = 24'd0;
            end
        end else if (!w_pulse && !r_holding && (w_dur > r_long)) begin
            n_hs      = w_dur;
            n_hp      = 24'd0;
            n_holding = 1'b1;
        end else if (!w_pulse && r_holding && (w_dur > r_long)) begin
            n_hs = irpsf_pkg::sat_add(irpsf_pkg::sat_add(r_hs, r_hp), w_dur);
            n_hp = 24'd0;
        end else if (!w_pulse && r_holding) begin
            w_word[0] = '{duration: r_hs, is_pulse: 1'b0, last_of_run: 1'b0};
            w_word[1] = '{duration: r_hp, is_pulse: 1'b1, last_of_run: 1'b0};
            w_push_n  = 2'd3;
            n_holding = 1'b0;
            n_hp      = 24'd0;
        end else begin
            w_push_n = 2'd1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // configuration registers and sense
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol        <= irpsf_pkg::RST_SENSE_INIT;
            r_glitch     <= irpsf_pkg::RST_GLITCH_LIM;
            r_long       <= irpsf_pkg::RST_LONG_SPACE;
            r_stale      <= irpsf_pkg::RST_STALE_SEC;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                irpsf_pkg::CFG_SENSE_INIT: r_pol    <= i_cfg_data[0];
                irpsf_pkg::CFG_GLITCH_LIM: r_glitch <= i_cfg_data;
                irpsf_pkg::CFG_LONG_SPACE: r_long   <= i_cfg_data;
                irpsf_pkg::CFG_STALE_SEC:  r_stale  <= i_cfg_data[7:0];
                default: ;
            endcase
        end else if (w_go) begin
            r_pol <= w_pol_eff;
        end
    end

    // timing and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sec  <= 32'd0;
            r_prev_usec <= 20'd0;
            r_holding   <= 1'b0;
            r_hs        <= 24'd0;
            r_hp        <= 24'd0;
        end else if (w_go) begin
            r_prev_sec  <= r_in.stamp_seconds;
            r_prev_usec <= r_in.stamp_micros;
            r_holding   <= n_holding;
            r_hs        <= n_hs;
            r_hp        <= n_hp;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (w_go) begin
                r_wp <= r_wp + w_push_n;
            end
            if (w_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= w_cnt_after_pop + (w_go ? {1'b0, w_push_n} : 3'd0);
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (w_go && (w_push_n != 2'd0)) begin
            r_queue[r_wp] <= w_word[0];
        end
        if (w_go && (w_push_n >= 2'd2)) begin
            r_queue[r_wp + 2'd1] <= w_word[1];
        end
        if (w_go && (w_push_n == 2'd3)) begin
            r_queue[r_wp + 2'd2] <= w_word[2];
        end
    end

    // checks
    `IRPSF_ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 3'd4)
    `IRPSF_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_out_valid && !w_pop, $stable(o_out_data))
    `IRPSF_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_vld && !w_go, r_in_vld && $stable(r_in))

endmodule

`default_nettype wire
